// ===== hw/rtl/rip_pkg.sv =====
`default_nettype none

package rip_pkg;

  // Fixed field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned RandW  = 31;
  localparam int unsigned PosW   = 6;
  localparam int unsigned EntryW = 6;
  localparam int unsigned CountW = 7;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // Defaults for the top-level parameters
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned RandomMaxDef  = 2147483647;
  localparam int unsigned CountRst      = 64;

  // Item kinds carried on tuser
  typedef enum logic [OpW-1:0] {
    OP_RESTART = 2'd0,
    OP_SWAP    = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [RandW-1:0] dividend;
    logic [RandW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RandW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rip_div.sv =====
`default_nettype none

module rip_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rip_pkg::div_req_t req_i,
  output rip_pkg::div_rsp_t      rsp_o
);
  import rip_pkg::*;

  localparam int unsigned CntW = $clog2(RandW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RandW-1:0] rem_q, rem_d;
  logic [RandW-1:0] quo_q, quo_d;
  logic [RandW-1:0] dvsr_q;
  logic [RandW:0]   shifted;
  logic             fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[RandW-1]};
    fits    = shifted >= {1'b0, dvsr_q};
    rem_d   = fits ? RandW'(shifted - {1'b0, dvsr_q}) : shifted[RandW-1:0];
    quo_d   = {quo_q[RandW-2:0], fits};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RandW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= req_i.dividend;
      dvsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/random_index_permutation.sv =====
`default_nettype none

// Forward Fisher-Yates shuffle of the indices 0..n-1, n = count saturated to
// TABLE_DEPTH. Items enter on the s_axis side, with the kind on tuser: restart
// reloads the identity at once, read registers one entry and then puts it
// plus the completion flag on m_axis once the output register is free, and a
// swap first uses a shared bit-serial divider to form RANDOM_MAX/(n-i) and
// then r/(that+1), one quotient bit per cycle, and then reads entry i, reads
// entry j, writes j and writes i through the single read and write port of
// the table. A swap that comes after the last one is dropped. The block takes
// one item at a time; tready is low while an item is at work.
// Reset and restart need no clearing pass: a valid bit per entry makes an
// untouched entry read as its own index.
module random_index_permutation #(
  parameter int unsigned TABLE_DEPTH = rip_pkg::TableDepthDef,
  parameter int unsigned RANDOM_MAX  = rip_pkg::RandomMaxDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration: count
  input  wire logic                         cfg_we_i,
  input  wire logic [rip_pkg::CountW-1:0]   cfg_wdata_i,
  // input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: random_word [30:0], position [36:31], zero [39:37]
  input  wire logic [rip_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: opcode [1:0]
  input  wire logic [rip_pkg::OpW-1:0]      s_axis_tuser,
  // output stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: entry [5:0], complete [6], zero [7]
  output logic [rip_pkg::OutDataW-1:0]      m_axis_tdata
);
  import rip_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW0  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW   = (NW0 > CountW) ? NW0 : CountW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV1 = 8'b0000_0010,
    S_DIV2 = 8'b0000_0100,
    S_RD_I = 8'b0000_1000,
    S_RD_J = 8'b0001_0000,
    S_WR_J = 8'b0010_0000,
    S_WR_I = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [IdxW-1:0]   step_q;
  logic [TABLE_DEPTH-1:0] valid_q;

  logic [IdxW-1:0] mem [TABLE_DEPTH];
  logic [IdxW-1:0] rdata_q;
  logic            rd_valid_q;
  logic [IdxW-1:0] rd_addr_q;
  logic [IdxW-1:0] rd_val;

  logic [NW-1:0]    n_q;
  logic [NW-1:0]    span_q;
  logic [RandW-1:0] rand_q;
  logic [IdxW-1:0]  j_q;
  logic [IdxW-1:0]  val_i_q, val_j_q;
  logic             in_range_q;
  logic             cmpl_q;

  logic              out_valid_q;
  logic [EntryW-1:0] out_entry_q;
  logic              out_cmpl_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Input unpacking
  logic             s_fire;
  op_e              op;
  logic [RandW-1:0] rand_in;
  logic [PosW-1:0]  pos_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign op      = op_e'(s_axis_tuser);
  assign rand_in = s_axis_tdata[RandW-1:0];
  assign pos_in  = s_axis_tdata[RandW+PosW-1:RandW];

  // Effective count and completion
  logic [NW-1:0] n_eff;
  logic [NW-1:0] span;
  logic          done;

  always_comb begin
    n_eff = (NW'(count_q) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_q);
    done  = (n_eff <= NW'(1)) || (NW'(step_q) + NW'(1) >= n_eff);
    span  = n_eff - NW'(step_q);
  end

  // Partner position, saturated to n-1
  logic [IdxW-1:0] j_calc;

  always_comb begin
    if (div_rsp.quotient >= RandW'(span_q)) begin
      j_calc = IdxW'(n_q - NW'(1));
    end else begin
      j_calc = IdxW'(NW'(step_q) + NW'(div_rsp.quotient));
    end
  end

  // Sequencer
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] mem_wdata;
  logic            load_out;

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    mem_raddr = step_q;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = val_i_q;
    load_out  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = RandW'(RANDOM_MAX);
    div_req.divisor  = RandW'(span);
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (op)
            OP_SWAP: begin
              if (!done) begin
                div_req.start = 1'b1;
                state_d       = S_DIV1;
              end
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = IdxW'(pos_in);
              state_d   = S_RESP;
            end
            default: ;
          endcase
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = rand_q;
          div_req.divisor  = div_rsp.quotient + RandW'(1);
          state_d          = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_d = S_RD_I;
        end
      end
      S_RD_I: begin
        mem_re    = 1'b1;
        mem_raddr = step_q;
        state_d   = S_RD_J;
      end
      S_RD_J: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
        state_d   = S_WR_J;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = val_i_q;
        state_d   = S_WR_I;
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = step_q;
        mem_wdata = val_j_q;
        state_d   = S_IDLE;
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  rip_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Table storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // An entry never written since restart reads as its own index
  assign rd_val = rd_valid_q ? rdata_q : rd_addr_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CountW'(CountRst);
      step_q  <= '0;
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (s_fire && op == OP_RESTART) begin
        step_q  <= '0;
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
        if (state_q == S_WR_I) begin
          step_q <= step_q + 1'b1;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_valid_q <= valid_q[mem_raddr];
      rd_addr_q  <= mem_raddr;
    end
    if (s_fire) begin
      rand_q     <= rand_in;
      n_q        <= n_eff;
      span_q     <= span;
      cmpl_q     <= done;
      in_range_q <= (32'(pos_in) < 32'(TABLE_DEPTH));
    end
    if (state_q == S_DIV2 && div_rsp.done) begin
      j_q <= j_calc;
    end
    if (state_q == S_RD_J) begin
      val_i_q <= rd_val;
    end
    if (state_q == S_WR_J) begin
      val_j_q <= rd_val;
    end
    if (load_out) begin
      out_entry_q <= in_range_q ? EntryW'(rd_val) : '0;
      out_cmpl_q  <= cmpl_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_cmpl_q, out_entry_q});

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rip_pkg::*;

  // Kind of a row in the directed table
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [OpW-1:0]     op;
    logic [RandW-1:0]   rword;
    logic [PosW-1:0]    pos;
    logic [CountW-1:0]  count_val;
    logic               typed;           // expected result given in the row
    logic [EntryW-1:0]  typed_entry;
    logic               typed_complete;
  } stim_row_t;

  typedef struct packed {
    logic [EntryW-1:0] entry;
    logic              complete;
  } read_result_t;

  localparam logic [OpW-1:0]   OpUnused    = 2'd3;
  localparam logic [RandW-1:0] RwMax       = 31'h7FFF_FFFF;
  localparam int unsigned      DrainCycles = 100;

  // Directed part: extremes, every kind, and the corner cases of the shuffle
  localparam int unsigned NumRows = 31;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // identity after reset
    '{ROW_ITEM, OP_READ,    31'd0,          6'd0,  7'd0,   1'b1, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd63, 7'd0,   1'b1, 6'd63, 1'b0},
    // unused opcode gives nothing
    '{ROW_ITEM, OpUnused,   RwMax,          6'd63, 7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    31'd0,          6'd63, 7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    RwMax,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    31'h2AAA_AAAA,  6'd21, 7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    31'h5555_5555,  6'd42, 7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    RwMax,          6'd1,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd63, 7'd0,   1'b0, 6'd0,  1'b0},
    // count lowered mid-shuffle: already complete
    '{ROW_CFG,  OP_RESTART, 31'd0,          6'd0,  7'd3,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd2,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    RwMax,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_RESTART, 31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd5,  7'd0,   1'b1, 6'd5,  1'b0},
    '{ROW_ITEM, OP_SWAP,    RwMax,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    31'h4000_0000,  6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    // swap past the last one is dropped
    '{ROW_ITEM, OP_SWAP,    31'd12345,      6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    // count of zero and one: always complete
    '{ROW_CFG,  OP_RESTART, 31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd7,  7'd0,   1'b1, 6'd7,  1'b1},
    '{ROW_ITEM, OP_SWAP,    RwMax,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_CFG,  OP_RESTART, 31'd0,          6'd0,  7'd1,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    // count above the table depth saturates
    '{ROW_CFG,  OP_RESTART, 31'd0,          6'd0,  7'd127, 1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_RESTART, 31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd63, 7'd0,   1'b1, 6'd63, 1'b0},
    // smallest real shuffle
    '{ROW_CFG,  OP_RESTART, 31'd0,          6'd0,  7'd2,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_RESTART, 31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_SWAP,    RwMax,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0},
    '{ROW_ITEM, OP_READ,    31'd0,          6'd0,  7'd0,   1'b0, 6'd0,  1'b0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CountW-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [OpW-1:0]       s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  random_index_permutation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shuffle model state
  logic [EntryW-1:0] perm_model [TableDepthDef];
  logic [CountW-1:0] step_model;
  logic [CountW-1:0] count_model;

  read_result_t pending_reads [$];
  int unsigned  mismatch_count = 0;
  int unsigned  src_idle_pct   = 16;
  int unsigned  sink_idle_pct  = 79;

  function automatic int unsigned eff_count();
    return (count_model > TableDepthDef) ? TableDepthDef : int'(count_model);
  endfunction

  function automatic bit shuffle_complete();
    int unsigned n;
    n = eff_count();
    return (n <= 1) || (step_model + 1 >= n);
  endfunction

  task automatic load_identity();
    for (int k = 0; k < TableDepthDef; k++) perm_model[k] = EntryW'(k);
    step_model = '0;
  endtask

  // Advance the model by one item; a read yields its result
  task automatic shuffle_model_apply(input logic [OpW-1:0] op, input logic [RandW-1:0] rw,
                                     input logic [PosW-1:0] pos, output bit has_read,
                                     output read_result_t res);
    longint unsigned n, span, div, j;
    logic [EntryW-1:0] tmp;
    has_read = 1'b0;
    res      = '0;
    n        = eff_count();
    case (op)
      OP_RESTART: load_identity();
      OP_SWAP: begin
        if (!shuffle_complete()) begin
          span = n - step_model;
          div  = longint'(RandomMaxDef) / span + 1;
          j    = step_model + longint'(rw) / div;
          if (j > n - 1) j = n - 1;
          tmp                    = perm_model[j];
          perm_model[j]          = perm_model[step_model];
          perm_model[step_model] = tmp;
          step_model             = step_model + 1'b1;
        end
      end
      OP_READ: begin
        has_read     = 1'b1;
        res.entry    = (pos < TableDepthDef) ? perm_model[pos] : '0;
        res.complete = shuffle_complete();
      end
      default: ;
    endcase
  endtask

  // Offer one item, wait for the transfer, then record what it should cause
  task automatic send_item(input logic [OpW-1:0] op, input logic [RandW-1:0] rw,
                           input logic [PosW-1:0] pos, input bit typed,
                           input logic [EntryW-1:0] t_entry, input logic t_complete);
    bit           has_read;
    read_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, rw};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    shuffle_model_apply(op, rw, pos, has_read, res);
    if (has_read) begin
      if (typed) begin
        res.entry    = t_entry;
        res.complete = t_complete;
      end
      pending_reads.push_back(res);
    end
  endtask

  // Write count once the block has drained
  task automatic write_count(input logic [CountW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_model  = value;
  endtask

  // Result side: random stalls and checking against the oldest expectation
  always @(posedge clk_i) begin
    read_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result transfer, actual %h", $time, m_axis_tdata);
      end else begin
        want = pending_reads.pop_front();
        if (m_axis_tdata[EntryW-1:0] !== want.entry) begin
          mismatch_count++;
          $display("%0t: entry mismatch, expected %0d, actual %0d", $time, want.entry,
                   m_axis_tdata[EntryW-1:0]);
        end
        if (m_axis_tdata[EntryW] !== want.complete) begin
          mismatch_count++;
          $display("%0t: complete mismatch, expected %0b, actual %0b", $time,
                   want.complete, m_axis_tdata[EntryW]);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Main stimulus
  initial begin
    int unsigned       accepted_items;
    int unsigned       seg_target;
    int unsigned       phase_len;
    int unsigned       roll;
    int unsigned       n;
    logic [31:0]       rnd;
    logic [OpW-1:0]    op;
    logic [RandW-1:0]  rw;
    logic [PosW-1:0]   pos;
    logic [CountW-1:0] cnt;

    load_identity();
    count_model = CountW'(CountRst);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirectedRows[k]) begin
      if (DirectedRows[k].kind == ROW_CFG) begin
        write_count(DirectedRows[k].count_val);
      end else begin
        send_item(DirectedRows[k].op, DirectedRows[k].rword, DirectedRows[k].pos,
                  DirectedRows[k].typed, DirectedRows[k].typed_entry,
                  DirectedRows[k].typed_complete);
      end
    end

    // random phases, three idling regimes
    accepted_items = 0;
    for (int seg = 0; seg < 3; seg++) begin
      case (seg)
        0: begin src_idle_pct = 16; sink_idle_pct = 79; end
        1: begin src_idle_pct = 79; sink_idle_pct = 16; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      seg_target = 120 * (seg + 1);
      while (accepted_items < seg_target) begin
        roll = $urandom_range(9);
        case (roll)
          0: cnt = 7'd0;
          1: cnt = 7'd1;
          2: cnt = 7'd127;
          3: cnt = 7'd64;
          4, 5, 6, 7: cnt = CountW'($urandom_range(2, 24));
          default: cnt = CountW'($urandom_range(25, 126));
        endcase
        write_count(cnt);
        // most phases are a proper shuffle from the identity
        if ($urandom_range(9) != 0) begin
          send_item(OP_RESTART, '0, '0, 1'b0, '0, 1'b0);
          accepted_items++;
        end
        phase_len = $urandom_range(10, 50);
        repeat (phase_len) begin
          roll = $urandom_range(99);
          if (roll < 50)      op = OP_SWAP;
          else if (roll < 88) op = OP_READ;
          else if (roll < 94) op = OP_RESTART;
          else                op = OpUnused;
          rnd = $urandom;
          case ($urandom_range(3))
            0: rw = '0;
            1: rw = RwMax;
            default: rw = rnd[RandW-1:0];
          endcase
          n   = eff_count();
          pos = PosW'($urandom_range(63));
          if (n > 0 && $urandom_range(1) == 0) pos = PosW'($urandom_range(n - 1));
          accepted_items++;
          send_item(op, rw, pos, 1'b0, '0, 1'b0);
        end
      end
    end

    // drain and report
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_reads.size() == 0) begin
      $display("random_index_permutation test passed");
    end else begin
      $display("random_index_permutation test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_500_000;
    $display("random_index_permutation test failed");
    $finish;
  end

endmodule
